/* src/region_table_access_checker_defines.svh */
// Assertion macros for the region table access checker.
`ifndef REGION_TABLE_ACCESS_CHECKER_DEFINES_SVH
`define REGION_TABLE_ACCESS_CHECKER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTAC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTAC_ASSERT(label, clk, rst_n, prop, msg)
`define RTAC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* src/rtac_pkg.sv */
package rtac_pkg;
    localparam int DEF_REGION_SLOTS = 16;
    localparam int DEF_PAGE_BITS    = 12;
    localparam int DEF_ADDR_BITS    = 48;
    localparam int FIELD_ADDR_BITS  = 48;
    localparam int SLOT_FIELD_BITS  = 4;

    localparam logic [2:0] ACT_MAP   = 3'd0;
    localparam logic [2:0] ACT_MAPDEV = 3'd1;
    localparam logic [2:0] ACT_UNMAP = 3'd2;
    localparam logic [2:0] ACT_CHECK = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_INVAL  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NONE   = 3'd3;
    localparam logic [2:0] ST_DENIED = 3'd4;

    localparam logic [1:0] KIND_ANON = 2'd0;
    localparam logic [1:0] KIND_FILE = 2'd1;
    localparam logic [1:0] KIND_DEV  = 2'd2;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        OP_MAP, OP_UNMAP, OP_CHECK, OP_CLEAR, OP_FAIL
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [FIELD_ADDR_BITS-1:0] addr;
        logic [FIELD_ADDR_BITS-1:0] end_addr;
        logic [2:0]                 bits;
        logic [1:0]                 kind;
        logic                       priv;
        logic                       file_bad;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic [2:0]                 fail_status;
    } t_cmd;

    typedef struct packed {
        logic [2:0]                 status;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic [1:0]                 kind;
        logic                       priv;
    } t_res;
endpackage

/* src/rtac_front.sv */
module rtac_front
    import rtac_pkg::*;
#(
    parameter int REGION_SLOTS = DEF_REGION_SLOTS,
    parameter int PAGE_BITS    = DEF_PAGE_BITS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  logic [2:0]                 i_action,
    input  logic [FIELD_ADDR_BITS-1:0] i_start,
    input  logic [FIELD_ADDR_BITS-1:0] i_end,
    input  logic [2:0]                 i_prot,
    input  logic [2:0]                 i_flags,
    input  logic                       i_fpres,
    input  logic [FIELD_ADDR_BITS-1:0] i_flo,
    input  logic [FIELD_ADDR_BITS-1:0] i_fhi,
    input  logic [2:0]                 i_need,
    input  logic [SLOT_FIELD_BITS-1:0] i_slot,
    output t_cmd                       o_cmd
);
    localparam int AB = (ADDR_BITS < FIELD_ADDR_BITS) ? ADDR_BITS : FIELD_ADDR_BITS;
    localparam logic [FIELD_ADDR_BITS-1:0] AMASK = {FIELD_ADDR_BITS{1'b1}} >> (FIELD_ADDR_BITS - AB);
    localparam logic [FIELD_ADDR_BITS-1:0] PMASK = (FIELD_ADDR_BITS'(1) << PAGE_BITS) - 1'b1;

    logic [FIELD_ADDR_BITS-1:0] s, e;
    logic range_ok, priv, shared, anon;

    always_comb begin
        s        = i_start & AMASK;
        e        = i_end & AMASK;
        priv     = i_flags[0];
        shared   = i_flags[1];
        anon     = i_flags[2];
        range_ok = ((s & PMASK) == '0) && ((e & PMASK) == '0) && (s < e);
        o_cmd    = '{op: OP_FAIL, addr: s, end_addr: e, bits: i_prot, kind: KIND_ANON,
                     priv: 1'b0, file_bad: 1'b0, slot: i_slot, fail_status: ST_INVAL};
        unique case (i_action)
            ACT_MAP: begin
                o_cmd.kind     = anon ? KIND_ANON : KIND_FILE;
                o_cmd.priv     = priv;
                o_cmd.file_bad = !anon && (!i_fpres || ((i_flo & PMASK) != '0) || (i_fhi < i_flo));
                if (range_ok && (priv != shared)) o_cmd.op = OP_MAP;
            end
            ACT_MAPDEV: begin
                o_cmd.kind = KIND_DEV;
                if (range_ok && !priv && shared && !i_prot[2]) o_cmd.op = OP_MAP;
            end
            ACT_UNMAP: begin
                if (32'(i_slot) < REGION_SLOTS) o_cmd.op = OP_UNMAP;
            end
            ACT_CHECK: begin
                o_cmd.op   = OP_CHECK;
                o_cmd.bits = i_need;
            end
            ACT_CLEAR: o_cmd.op = OP_CLEAR;
            default: o_cmd.op = OP_FAIL;
        endcase
    end
endmodule

/* src/rtac_queue.sv */
module rtac_queue
    import rtac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);
    t_cmd       r_mem [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

/* src/rtac_back.sv */
module rtac_back
    import rtac_pkg::*;
#(
    parameter int REGION_SLOTS = DEF_REGION_SLOTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);
    localparam int SW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_OUT = 2'd2;

    logic [1:0]                 r_state;
    logic [REGION_SLOTS-1:0]    r_valid;
    logic [FIELD_ADDR_BITS-1:0] r_start [REGION_SLOTS];
    logic [FIELD_ADDR_BITS-1:0] r_endv  [REGION_SLOTS];
    logic [2:0]                 r_rights[REGION_SLOTS];
    logic [1:0]                 r_kind  [REGION_SLOTS];
    logic                       r_priv  [REGION_SLOTS];
    logic [31:0]                r_age   [REGION_SLOTS];
    logic [31:0]                r_ctr;
    logic [CW-1:0]              r_idx;
    logic                       r_found;
    logic [SW-1:0]              r_best;
    logic [31:0]                r_bestd;
    t_cmd                       r_cmd;
    t_res                       r_res;

    logic [SW-1:0] idx;
    logic [31:0]   d;
    logic          hit;

    assign idx         = r_idx[SW-1:0];
    assign o_res_valid = r_state == S_OUT;
    assign o_res       = r_res;
    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign d           = r_ctr - r_age[idx];
    assign hit = r_valid[idx] && (r_start[idx] <= r_cmd.addr) && (r_cmd.addr < r_endv[idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ctr   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd   <= i_cmd;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    unique case (i_cmd.op)
                        OP_MAP, OP_CHECK: begin
                            r_res   <= '{status: ST_OK, slot: '0, kind: '0, priv: 1'b0};
                            r_state <= S_SCAN;
                        end
                        OP_UNMAP: begin
                            r_valid[i_cmd.slot[SW-1:0]] <= 1'b0;
                            r_res   <= '{status: ST_OK, slot: '0, kind: '0, priv: 1'b0};
                            r_state <= S_OUT;
                        end
                        OP_CLEAR: begin
                            r_valid <= '0;
                            r_res   <= '{status: ST_OK, slot: '0, kind: '0, priv: 1'b0};
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_res   <= '{status: i_cmd.fail_status, slot: '0, kind: '0,
                                         priv: 1'b0};
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (r_cmd.op == OP_MAP) begin
                        if (!r_valid[idx]) begin
                            if (r_cmd.file_bad) r_res.status <= ST_INVAL;
                            else begin
                                r_valid[idx]  <= 1'b1;
                                r_start[idx]  <= r_cmd.addr;
                                r_endv[idx]   <= r_cmd.end_addr;
                                r_rights[idx] <= r_cmd.bits;
                                r_kind[idx]   <= r_cmd.kind;
                                r_priv[idx]   <= r_cmd.priv;
                                r_age[idx]    <= r_ctr;
                                r_ctr         <= r_ctr + 32'd1;
                                r_res <= '{status: ST_OK, slot: SLOT_FIELD_BITS'(idx),
                                           kind: r_cmd.kind, priv: r_cmd.priv};
                            end
                            r_state <= S_OUT;
                        end else if (32'(r_idx) == REGION_SLOTS - 1) begin
                            r_res.status <= ST_FULL;
                            r_state <= S_OUT;
                        end
                        r_idx <= r_idx + CW'(1);
                    end else if (32'(r_idx) == REGION_SLOTS) begin
                        if (!r_found) r_res.status <= ST_NONE;
                        else begin
                            r_res.slot <= SLOT_FIELD_BITS'(r_best);
                            r_res.kind <= r_kind[r_best];
                            r_res.priv <= r_priv[r_best];
                            if ((r_cmd.bits & ~r_rights[r_best]) != 3'b000)
                                r_res.status <= ST_DENIED;
                            else r_res.status <= ST_OK;
                        end
                        r_state <= S_OUT;
                    end else begin
                        if (hit && (!r_found || d < r_bestd)) begin
                            r_found <= 1'b1;
                            r_best  <= idx;
                            r_bestd <= d;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_OUT: if (i_res_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* src/region_table_access_checker.sv */
// Region table access checker. Items enter through a classifier into a
// two-deep queue; the table engine walks one slot per cycle. Unmap, clear
// and rejected items skip the scan; a map stops at the lowest free slot
// and a check walks every slot of the table. The next item is accepted
// while the engine works until the queue is full.
`include "region_table_access_checker_defines.svh"
module region_table_access_checker
    import rtac_pkg::*;
#(
    parameter int REGION_SLOTS = DEF_REGION_SLOTS,
    parameter int PAGE_BITS    = DEF_PAGE_BITS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0], start_addr[50:3], end_addr[98:51], prot_bits[101:99],
    // map_flags[104:102], file_present[105], file_low[153:106],
    // file_high[201:154], need_bits[204:202], slot[208:205], zero fill
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], result_slot[6:3], region_kind[8:7], region_private[9], zero fill
    output logic [15:0]  m_axis_tdata
);
    t_cmd f_cmd, q_cmd;
    t_res res;
    logic q_full, q_valid, pop;

    rtac_front #(.REGION_SLOTS(REGION_SLOTS), .PAGE_BITS(PAGE_BITS),
                 .ADDR_BITS(ADDR_BITS)) u_front (
        .i_action(s_axis_tdata[2:0]), .i_start(s_axis_tdata[50:3]),
        .i_end(s_axis_tdata[98:51]), .i_prot(s_axis_tdata[101:99]),
        .i_flags(s_axis_tdata[104:102]), .i_fpres(s_axis_tdata[105]),
        .i_flo(s_axis_tdata[153:106]), .i_fhi(s_axis_tdata[201:154]),
        .i_need(s_axis_tdata[204:202]), .i_slot(s_axis_tdata[208:205]),
        .o_cmd(f_cmd)
    );

    assign s_axis_tready = !q_full;

    rtac_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid && !q_full), .i_data(f_cmd), .o_full(q_full),
        .i_pop(pop), .o_valid(q_valid), .o_data(q_cmd)
    );

    rtac_back #(.REGION_SLOTS(REGION_SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_pop(pop), .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_res(res)
    );

    assign m_axis_tdata = {6'd0, res.priv, res.kind, res.slot, res.status};

    `RTAC_ASSERT(a_pop_valid, i_clk, i_rst_n, pop |-> q_valid, "pop from empty queue")
    `RTAC_ASSERT(a_no_pop_out, i_clk, i_rst_n, m_axis_tvalid |-> !pop, "pop while result held")
    `RTAC_ASSERT(a_kind_ok, i_clk, i_rst_n, m_axis_tvalid |-> res.kind != 2'd3, "bad kind")
endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import rtac_pkg::*;

    localparam int NSLOT = DEF_REGION_SLOTS;
    localparam logic [2:0] ACT_BAD = 3'd5;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] start_addr;
        logic [47:0] end_addr;
        logic [2:0]  prot_bits;
        logic [2:0]  map_flags;
        logic        file_present;
        logic [47:0] file_low;
        logic [47:0] file_high;
        logic [2:0]  need_bits;
        logic [3:0]  slot;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [1:0] kind;
        logic       priv;
    } resp_t;

    typedef struct {
        req_t  rq;
        bit    fixed;
        resp_t want;
    } row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;

    region_table_access_checker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // table mirror
    bit          t_valid [NSLOT];
    logic [47:0] t_start [NSLOT];
    logic [47:0] t_end   [NSLOT];
    logic [2:0]  t_rights[NSLOT];
    logic [1:0]  t_kind  [NSLOT];
    logic        t_priv  [NSLOT];
    logic [31:0] t_age   [NSLOT];
    logic [31:0] insert_count;

    resp_t pending_resp[$];
    int    fail_count;
    int    mismatch_count;
    bit    sending_done;
    row_t  rows[$];

    function automatic bit aligned(logic [47:0] a);
        return a[11:0] == 12'd0;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < NSLOT; i++)
            if (!t_valid[i]) return i;
        return -1;
    endfunction

    function automatic resp_t apply_request(req_t r);
        resp_t o;
        bit range_ok, pv, sh, an;
        int f, best;
        logic [31:0] bd, d;
        o = '0;
        pv = r.map_flags[0];
        sh = r.map_flags[1];
        an = r.map_flags[2];
        range_ok = aligned(r.start_addr) && aligned(r.end_addr) && r.start_addr < r.end_addr;
        case (r.action)
            ACT_MAP, ACT_MAPDEV: begin
                if (r.action == ACT_MAP ? (!range_ok || pv == sh)
                        : (!range_ok || pv || !sh || r.prot_bits[2])) begin
                    o.status = ST_INVAL;
                    return o;
                end
                f = lowest_free();
                if (f < 0) begin
                    o.status = ST_FULL;
                    return o;
                end
                if (r.action == ACT_MAP && !an && (!r.file_present || !aligned(r.file_low)
                        || r.file_high < r.file_low)) begin
                    o.status = ST_INVAL;
                    return o;
                end
                t_valid[f] = 1;
                t_start[f] = r.start_addr;
                t_end[f] = r.end_addr;
                t_rights[f] = r.prot_bits;
                t_kind[f] = r.action == ACT_MAPDEV ? KIND_DEV : (an ? KIND_ANON : KIND_FILE);
                t_priv[f] = r.action == ACT_MAPDEV ? 1'b0 : pv;
                t_age[f] = insert_count;
                insert_count++;
                o.status = ST_OK;
                o.slot = f[3:0];
                o.kind = t_kind[f];
                o.priv = t_priv[f];
            end
            ACT_UNMAP: t_valid[r.slot] = 0;
            ACT_CHECK: begin
                best = -1;
                bd = '0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (t_valid[i] && t_start[i] <= r.start_addr && r.start_addr < t_end[i]) begin
                        d = insert_count - t_age[i];
                        if (best < 0 || d < bd) begin
                            best = i;
                            bd = d;
                        end
                    end
                end
                if (best < 0) begin
                    o.status = ST_NONE;
                    return o;
                end
                o.slot = best[3:0];
                o.kind = t_kind[best];
                o.priv = t_priv[best];
                if ((r.need_bits & ~t_rights[best]) != 3'd0) o.status = ST_DENIED;
            end
            ACT_CLEAR: for (int i = 0; i < NSLOT; i++) t_valid[i] = 0;
            default: o.status = ST_INVAL;
        endcase
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb NOT OK");
        $finish;
    end

    // page-aligned random address, mostly in a small window so that regions overlap
    function automatic logic [47:0] page_addr();
        if ($urandom_range(0, 9) == 0) return 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000;
        return {36'd0, 12'd0} | (48'($urandom_range(0, 31)) << 12);
    endfunction

    function automatic req_t rand_request();
        req_t r;
        int p;
        r = '0;
        r.start_addr = 48'({$urandom, $urandom});
        r.end_addr = 48'({$urandom, $urandom});
        r.file_low = 48'({$urandom, $urandom});
        r.file_high = 48'({$urandom, $urandom});
        r.prot_bits = 3'($urandom);
        r.map_flags = 3'($urandom);
        r.file_present = 1'($urandom);
        r.need_bits = 3'($urandom);
        r.slot = 4'($urandom);
        p = $urandom_range(0, 99);
        if (p < 30) begin
            r.action = ACT_MAP;
            if (p < 27) begin
                r.start_addr = page_addr();
                r.end_addr = r.start_addr + (48'($urandom_range(1, 8)) << 12);
                r.map_flags = {1'($urandom), 2'($urandom_range(1, 2))};
                r.file_present = $urandom_range(0, 5) != 0;
                r.file_low = $urandom_range(0, 5) ? r.file_low & 48'hFFFF_FFFF_F000 : r.file_low;
                if ($urandom_range(0, 3) != 0 && r.file_high < r.file_low)
                    r.file_high = r.file_low + 48'($urandom);
            end
        end else if (p < 40) begin
            r.action = ACT_MAPDEV;
            if (p < 38) begin
                r.start_addr = page_addr();
                r.end_addr = r.start_addr + (48'($urandom_range(1, 8)) << 12);
                r.map_flags[1:0] = $urandom_range(0, 4) ? 2'b10 : 2'($urandom);
                if ($urandom_range(0, 3)) r.prot_bits[2] = 0;
            end
        end else if (p < 55) begin
            r.action = ACT_UNMAP;
        end else if (p < 93) begin
            r.action = ACT_CHECK;
            r.start_addr = $urandom_range(0, 7) ? 48'($urandom_range(0, 40 << 12)) : r.start_addr;
        end else if (p < 96) begin
            r.action = ACT_CLEAR;
        end else begin
            r.action = 3'($urandom_range(5, 7));
        end
        return r;
    endfunction

    task automatic send_item(req_t r);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tdata <= {7'd0, r.slot, r.need_bits, r.file_high, r.file_low, r.file_present,
                         r.map_flags, r.prot_bits, r.end_addr, r.start_addr, r.action};
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_resp.push_back(apply_request(r));
        @(negedge i_clk);
    endtask

    function automatic row_t mk(logic [2:0] a, logic [47:0] s, logic [47:0] e,
                                logic [2:0] pr, logic [2:0] fl, bit fixed,
                                logic [2:0] st);
        row_t w;
        w.rq = '0;
        w.rq.action = a;
        w.rq.start_addr = s;
        w.rq.end_addr = e;
        w.rq.prot_bits = pr;
        w.rq.map_flags = fl;
        w.rq.file_present = 1;
        w.rq.file_high = 48'h1000;
        w.rq.need_bits = pr;
        w.fixed = fixed;
        w.want = '0;
        w.want.status = st;
        return w;
    endfunction

    initial begin
        row_t w;
        resp_t exp_r;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        fail_count = 0;
        mismatch_count = 0;
        sending_done = 0;
        for (int i = 0; i < NSLOT; i++) t_valid[i] = 0;
        insert_count = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        rows.push_back(mk(ACT_CHECK, 48'h0, 0, 3'd1, 0, 1, ST_NONE));
        rows.push_back(mk(ACT_MAP, 48'h1000, 48'h1000, 7, 3'b001, 1, ST_INVAL));
        rows.push_back(mk(ACT_MAP, 48'h1001, 48'h2000, 7, 3'b001, 1, ST_INVAL));
        rows.push_back(mk(ACT_MAP, 48'h1000, 48'h2000, 7, 3'b011, 1, ST_INVAL));
        rows.push_back(mk(ACT_MAP, 48'h1000, 48'h2000, 7, 3'b100, 1, ST_INVAL));
        rows.push_back(mk(ACT_MAP, 48'h0, 48'hFFFF_FFFF_F000, 3'd1, 3'b101, 0, 0));
        rows.push_back(mk(ACT_MAP, 48'h2000, 48'h4000, 3'd6, 3'b010, 0, 0));
        w = mk(ACT_MAP, 48'h2000, 48'h4000, 3'd7, 3'b010, 1, ST_INVAL);
        w.rq.file_present = 0;
        rows.push_back(w);
        w = mk(ACT_MAP, 48'h2000, 48'h4000, 3'd7, 3'b010, 1, ST_INVAL);
        w.rq.file_low = 48'h10;
        rows.push_back(w);
        w = mk(ACT_MAP, 48'h2000, 48'h4000, 3'd7, 3'b010, 1, ST_INVAL);
        w.rq.file_low = 48'h2000;
        rows.push_back(w);
        rows.push_back(mk(ACT_MAPDEV, 48'h3000, 48'h5000, 3'd4, 3'b010, 1, ST_INVAL));
        rows.push_back(mk(ACT_MAPDEV, 48'h3000, 48'h5000, 3'd3, 3'b011, 1, ST_INVAL));
        rows.push_back(mk(ACT_MAPDEV, 48'h3000, 48'h5000, 3'd3, 3'b110, 0, 0));
        rows.push_back(mk(ACT_CHECK, 48'h3000, 0, 3'd3, 0, 0, 0));
        rows.push_back(mk(ACT_CHECK, 48'h3FFF, 0, 3'd4, 0, 0, 0));
        rows.push_back(mk(ACT_CHECK, 48'hFFFF_FFFF_FFFF, 0, 3'd1, 0, 1, ST_NONE));
        rows.push_back(mk(ACT_CHECK, 48'hFFFF_FFFF_EFFF, 0, 3'd2, 0, 0, 0));
        w = mk(ACT_UNMAP, 0, 0, 0, 0, 1, ST_OK);
        w.rq.slot = 4'd15;
        rows.push_back(w);
        w = mk(ACT_UNMAP, 0, 0, 0, 0, 1, ST_OK);
        w.rq.slot = 4'd1;
        rows.push_back(w);
        rows.push_back(mk(ACT_CHECK, 48'h2000, 0, 3'd0, 0, 0, 0));
        rows.push_back(mk(ACT_BAD, 0, 0, 0, 0, 1, ST_INVAL));
        rows.push_back(mk(3'd7, 0, 0, 0, 0, 1, ST_INVAL));
        for (int i = 0; i < NSLOT + 1; i++)
            rows.push_back(mk(ACT_MAP, 48'h8000, 48'h9000, 3'd3, 3'b101, 0, 0));
        rows.push_back(mk(ACT_MAPDEV, 48'h8000, 48'h9000, 3'd3, 3'b010, 1, ST_FULL));
        rows.push_back(mk(ACT_CHECK, 48'h8000, 0, 3'd3, 0, 0, 0));
        rows.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 1, ST_OK));
        rows.push_back(mk(ACT_CHECK, 48'h8000, 0, 3'd3, 0, 1, ST_NONE));

        foreach (rows[k]) begin
            exp_r = apply_request(rows[k].rq);
            if (rows[k].fixed && exp_r != rows[k].want) begin
                fail_count++;
                $display("table row %0d disagrees with predictor", k);
            end
        end
        for (int i = 0; i < NSLOT; i++) t_valid[i] = 0;
        insert_count = 0;
        foreach (rows[k]) send_item(rows[k].rq);

        s_axis_tvalid <= 0;
        @(negedge i_clk);
        while (pending_resp.size() != 0) @(negedge i_clk);
        for (int n = 0; n < 850; n++) begin
            if (n == 400) begin
                s_axis_tvalid <= 0;
                @(negedge i_clk);
                while (pending_resp.size() != 0) @(negedge i_clk);
            end
            send_item(rand_request());
        end
        s_axis_tvalid <= 0;
        sending_done = 1;
    end

    initial begin
        int g;
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if ($urandom_range(0, 3) == 0 && g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(negedge i_clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        resp_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[8:7], m_axis_tdata[9]};
            if (pending_resp.size() == 0) begin
                fail_count++;
                if (mismatch_count++ < 10) $display("unexpected item %h", got);
            end else begin
                want = pending_resp.pop_front();
                if (got != want) begin
                    fail_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch: status %0d/%0d slot %0d/%0d kind %0d/%0d priv %0d/%0d",
                                 want.status, got.status, want.slot, got.slot,
                                 want.kind, got.kind, want.priv, got.priv);
                end
            end
        end
    end

    initial begin
        wait (sending_done);
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_resp.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
